@@ sv/hlde_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlde_pkg
// Shared types and constants for the hosts line domain extractor.
// ----------------------------------------------------------------------------
package hlde_pkg;

  // input item kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_STALL   = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  // result kinds
  localparam logic [1:0] RK_CHAR   = 2'd0;
  localparam logic [1:0] RK_COMMIT = 2'd1;
  localparam logic [1:0] RK_ABORT  = 2'd2;
  localparam logic [1:0] RK_FINAL  = 2'd3;

  // final status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LARGE   = 3'd1;
  localparam logic [2:0] ST_TRIMMED = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_DOMAIN_CAP = 2'd0;
  localparam logic [1:0] REG_WARN_COUNT = 2'd1;
  localparam logic [1:0] REG_STALL_OK   = 2'd2;

  localparam logic [15:0] DOMAIN_CAP_RST = 16'd50000;
  localparam logic [15:0] WARN_COUNT_RST = 16'd40000;
  localparam logic [15:0] STALL_OK_RST   = 16'd5000;

  // characters of interest
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam logic [8:0] HELD_CR_MAX = 9'd511;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    CL_OTHER,
    CL_NL,
    CL_BLANK,
    CL_CR,
    CL_NUL,
    CL_HASH
  } byte_class_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  domain_char;
    logic [8:0]  cr_before;
    logic [2:0]  status;
    logic [15:0] domain_count;
  } result_t;

  // classified item as held in the queue
  typedef struct packed {
    logic [1:0]  kind;
    byte_class_t cls;
    logic [7:0]  data_byte;
  } q_entry_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

@@ sv/hlde_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlde_front
// Accepts input transactions and tags each data byte with its class.
// ----------------------------------------------------------------------------
module hlde_front
  import hlde_pkg::*;
(
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire item_t    item,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_wdata
);

  byte_class_t cls;

  always_comb begin
    priority if (item.data_byte == CH_NL) begin
      cls = CL_NL;
    end else if (item.data_byte == CH_SP || item.data_byte == CH_TAB) begin
      cls = CL_BLANK;
    end else if (item.data_byte == CH_CR) begin
      cls = CL_CR;
    end else if (item.data_byte == CH_NUL) begin
      cls = CL_NUL;
    end else if (item.data_byte == CH_HASH) begin
      cls = CL_HASH;
    end else begin
      cls = CL_OTHER;
    end
  end

  assign item_stall        = q_full;
  assign q_push            = item_valid && !q_full;
  assign q_wdata.kind      = item.kind;
  assign q_wdata.cls       = cls;
  assign q_wdata.data_byte = item.data_byte;

endmodule
`default_nettype wire

@@ sv/hlde_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlde_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module hlde_queue
  import hlde_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire q_entry_t  wdata,
  input  wire logic      pop,
  output q_entry_t       rdata,
  output logic           full,
  output logic           not_empty
);

  q_entry_t         mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_AW:0]    fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign rdata     = mem[rd_ptr];
  assign full      = (fill == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (fill != '0);

endmodule
`default_nettype wire

@@ sv/hlde_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlde_back
// Line parser: walks the phases of a hosts line, holds the domain counters
// and drives the registered result stage.
// ----------------------------------------------------------------------------
module hlde_back
  import hlde_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = 512
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_wr_t   cfg,
  input  wire logic      q_not_empty,
  input  wire q_entry_t  q_rdata,
  output logic           q_pop,
  output logic           result_valid,
  input  wire logic      result_stall,
  output result_t        result
);

  localparam int LL_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LL_W-1:0] LL_LIMIT = LL_W'(LINE_BUFFER_BYTES - 1);

  typedef enum logic [4:0] {
    PH_LEAD = 5'b00001,
    PH_ADDR = 5'b00010,
    PH_GAP  = 5'b00100,
    PH_HOST = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  logic [15:0] domain_cap;
  logic [15:0] warn_count;
  logic [15:0] stall_ok_count;

  phase_t          phase, phase_next;
  logic [LL_W-1:0] line_length, line_length_next;
  logic [8:0]      held_returns, held_returns_next;
  logic            host_emitted, host_emitted_next;
  logic [15:0]     committed_count, committed_count_next;
  logic            large_flag, large_flag_next;
  logic            halted_flag, halted_flag_next;

  logic            step;
  logic            res_fire;
  result_t         res;
  logic [15:0]     count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_cap     <= DOMAIN_CAP_RST;
      warn_count     <= WARN_COUNT_RST;
      stall_ok_count <= STALL_OK_RST;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_DOMAIN_CAP: domain_cap     <= cfg.data;
        REG_WARN_COUNT: warn_count     <= cfg.data;
        REG_STALL_OK:   stall_ok_count <= cfg.data;
        default: ;
      endcase
    end
  end

  assign step      = q_not_empty && (!result_valid || !result_stall);
  assign q_pop     = step;
  assign count_inc = committed_count + 16'd1;

  always_comb begin
    phase_next           = phase;
    line_length_next     = line_length;
    held_returns_next    = held_returns;
    host_emitted_next    = host_emitted;
    committed_count_next = committed_count;
    large_flag_next      = large_flag;
    halted_flag_next     = halted_flag;
    res_fire             = 1'b0;
    res                  = '0;

    if (q_rdata.kind != KIND_DATA) begin
      res_fire         = 1'b1;
      res.result_kind  = RK_FINAL;
      res.domain_count = committed_count;
      priority if (halted_flag) begin
        res.status = ST_TRIMMED;
      end else if (q_rdata.kind == KIND_TIMEOUT) begin
        res.status = ST_TIMEOUT;
      end else if (q_rdata.kind == KIND_STALL && committed_count >= stall_ok_count) begin
        res.status = ST_OK;
      end else if (large_flag || committed_count >= warn_count) begin
        res.status = ST_LARGE;
      end else if (committed_count == '0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_OK;
      end
      // fresh stream
      phase_next           = PH_LEAD;
      line_length_next     = '0;
      held_returns_next    = '0;
      host_emitted_next    = 1'b0;
      committed_count_next = '0;
      large_flag_next      = 1'b0;
      halted_flag_next     = 1'b0;
    end else if (!halted_flag) begin
      if (q_rdata.cls == CL_NL) begin
        phase_next        = PH_LEAD;
        line_length_next  = '0;
        held_returns_next = '0;
        host_emitted_next = 1'b0;
        if (host_emitted) begin
          res_fire = 1'b1;
          if (committed_count >= domain_cap) begin
            halted_flag_next = 1'b1;
            res.result_kind  = RK_ABORT;
          end else begin
            committed_count_next = count_inc;
            if (count_inc == warn_count) large_flag_next = 1'b1;
            res.result_kind = RK_COMMIT;
          end
        end
      end else if (line_length >= LL_LIMIT) begin
        // line buffer overflow: restart the line
        phase_next        = PH_LEAD;
        line_length_next  = '0;
        held_returns_next = '0;
        host_emitted_next = 1'b0;
        if (host_emitted) begin
          res_fire        = 1'b1;
          res.result_kind = RK_ABORT;
        end
      end else begin
        line_length_next = line_length + 1'b1;
        unique case (phase)
          PH_LEAD: begin
            unique case (q_rdata.cls)
              CL_BLANK, CL_CR: ;
              CL_NUL, CL_HASH: phase_next = PH_DONE;
              default:         phase_next = PH_ADDR;
            endcase
          end
          PH_ADDR: begin
            if (q_rdata.cls == CL_BLANK) phase_next = PH_GAP;
            else if (q_rdata.cls == CL_NUL) phase_next = PH_DONE;
          end
          PH_GAP, PH_HOST: begin
            unique case (q_rdata.cls)
              CL_BLANK: begin
                if (phase == PH_HOST) phase_next = PH_DONE;
              end
              CL_NUL, CL_HASH: phase_next = PH_DONE;
              CL_CR: begin
                phase_next = PH_HOST;
                if (phase == PH_GAP) begin
                  held_returns_next = 9'd1;
                end else if (held_returns < HELD_CR_MAX) begin
                  held_returns_next = held_returns + 9'd1;
                end
              end
              default: begin
                res_fire          = 1'b1;
                res.result_kind   = RK_CHAR;
                res.domain_char   = q_rdata.data_byte;
                res.cr_before     = held_returns;
                held_returns_next = '0;
                host_emitted_next = 1'b1;
                phase_next        = PH_HOST;
              end
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEAD;
      line_length     <= '0;
      held_returns    <= '0;
      host_emitted    <= 1'b0;
      committed_count <= '0;
      large_flag      <= 1'b0;
      halted_flag     <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (step) begin
        phase           <= phase_next;
        line_length     <= line_length_next;
        held_returns    <= held_returns_next;
        host_emitted    <= host_emitted_next;
        committed_count <= committed_count_next;
        large_flag      <= large_flag_next;
        halted_flag     <= halted_flag_next;
        result_valid    <= res_fire;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_fire) begin
      result <= res;
    end
  end

  // held CRs only exist once the host has started; a cut host keeps them
  a_held_in_host: assert property (@(posedge clk) disable iff (rst)
    held_returns != '0 |-> (phase == PH_HOST || phase == PH_DONE))
    else $error("held CR count outside host phase");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LL_LIMIT)
    else $error("line length beyond buffer");

  a_emitted_phase: assert property (@(posedge clk) disable iff (rst)
    host_emitted |-> (phase == PH_HOST || phase == PH_DONE))
    else $error("host emitted in wrong phase");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && q_rdata.kind != KIND_DATA |=>
      committed_count == '0 && !halted_flag && !large_flag && result_valid)
    else $error("end transaction did not reset the stream");

endmodule
`default_nettype wire

@@ sv/hosts_line_domain_extractor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hosts_line_domain_extractor
// Pulls the host token out of each line of a hosts-file byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item. Each transaction is a
//                    data byte or an end marker (normal, stall, timeout).
//   result channel : result_valid / result_stall / result. At most one
//                    result per input transaction: a host character with
//                    its held CR count, a commit, an abort or a final status.
//   cfg port       : cfg_write / cfg_index / cfg_data, written only while
//                    idle; out-of-range indexes are ignored.
// With the queue empty, an accepted transaction is written into the queue and
// then into the result register. Throughput is one transaction per cycle while
// result_stall is low; the single parser state update in the back end sets it.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// loads the register defaults (cap 50000, warn 40000, stall-ok 5000).
// When result_stall is held the result register keeps its transaction; the
// four-entry queue keeps absorbing input, and item_stall rises once it fills.
// ----------------------------------------------------------------------------
module hosts_line_domain_extractor
  import hlde_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = 512
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_not_empty;
  cfg_wr_t  cfg;

  assign cfg.we    = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front end: classify the byte and push it into the queue
  hlde_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // decouples input acceptance from result back-pressure
  hlde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // back end: line parser, counters and result register
  hlde_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ sim/hosts_line_domain_extractor_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hosts_line_domain_extractor_test
// Self-checking bench for the hosts-file host extractor. A behavioural
// predictor follows every accepted input transaction and queues the result
// it should cause; a monitor pops and compares each result transaction.
// Directed lines cover comments, CR handling, NUL, buffer overflow, the
// domain cap and every end status; a long random run of mostly well-formed
// lines follows, with random idling on both channels.
// ----------------------------------------------------------------------------
module hosts_line_domain_extractor_test;
  import hlde_pkg::*;

  localparam int LINE_BYTES    = 512;   // matches the DUT default
  localparam int SETTLE_CYCLES = 12;    // pipeline plus the four-entry queue
  localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int RANDOM_ITEMS  = 720;

  // parser phase of the line currently being read
  typedef enum logic [2:0] {PH_LEAD, PH_ADDR, PH_GAP, PH_HOST, PH_DONE} line_phase_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of the registers and the parser state
  logic [15:0] dom_cap;
  logic [15:0] warn_at;
  logic [15:0] stall_ok;
  logic [15:0] n_domains;
  line_phase_t phase;
  int          line_len;
  logic [8:0]  held_cr;
  bit          host_seen;
  bit          big_list;
  bit          halted;

  result_t expected_results[$];
  result_t want;
  int      fails       = 0;
  int      items_taken = 0;   // transactions the parser actually acts on
  bit      bursts_on   = 1'b0;
  int      stall_left  = 0;
  int      quiet_cycles = 0;

  hosts_line_domain_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Host extraction predictor
  // --------------------------------------------------------------------------
  function automatic void restart_line();
    phase     = PH_LEAD;
    line_len  = 0;
    held_cr   = '0;
    host_seen = 1'b0;
  endfunction

  function automatic void restart_stream();
    restart_line();
    n_domains = '0;
    big_list  = 1'b0;
    halted    = 1'b0;
  endfunction

  // Works out what one accepted transaction yields, if anything, and queues it.
  function automatic void predict_item(input item_t it);
    result_t    r;
    logic [7:0] c;
    bit         blank;
    bit         produced;
    bit         take_char;
    r         = '0;
    c         = it.data_byte;
    blank     = (c == CH_SP) || (c == CH_TAB);
    produced  = 1'b0;
    take_char = 1'b0;
    if (it.kind == KIND_DATA) begin
      if (halted) return;  // halted stream swallows data
      if (c == CH_NL) begin
        // newline: commit a non-empty host, or trip the cap
        if (host_seen) begin
          produced = 1'b1;
          if (n_domains >= dom_cap) begin
            halted        = 1'b1;
            r.result_kind = RK_ABORT;
          end else begin
            n_domains++;
            if (n_domains == warn_at) big_list = 1'b1;
            r.result_kind = RK_COMMIT;
          end
        end
        restart_line();
      end else if (line_len >= LINE_BYTES - 1) begin
        // line buffer full: byte dropped, line restarts, any host is withdrawn
        if (host_seen) begin
          produced      = 1'b1;
          r.result_kind = RK_ABORT;
        end
        restart_line();
      end else begin
        line_len++;
        case (phase)
          PH_LEAD: begin
            if (!(blank || c == CH_CR))
              phase = (c == CH_NUL || c == CH_HASH) ? PH_DONE : PH_ADDR;
          end
          PH_ADDR: begin
            if (blank) phase = PH_GAP;
            else if (c == CH_NUL) phase = PH_DONE;
          end
          PH_GAP: begin
            if (c == CH_NUL || c == CH_HASH) phase = PH_DONE;
            else if (c == CH_CR) begin
              held_cr = 9'd1;
              phase   = PH_HOST;
            end else if (!blank) take_char = 1'b1;
          end
          PH_HOST: begin
            if (blank || c == CH_NUL || c == CH_HASH) phase = PH_DONE;
            else if (c == CH_CR) begin
              if (held_cr != HELD_CR_MAX) held_cr++;
            end else take_char = 1'b1;
          end
          default: ;
        endcase
        if (take_char) begin
          produced      = 1'b1;
          r.result_kind = RK_CHAR;
          r.domain_char = c;
          r.cr_before   = held_cr;
          held_cr       = '0;
          host_seen     = 1'b1;
          phase         = PH_HOST;
        end
      end
    end else begin
      // end marker: report status and count, then start a fresh stream
      produced      = 1'b1;
      r.result_kind = RK_FINAL;
      if (it.kind == KIND_TIMEOUT) r.status = halted ? ST_TRIMMED : ST_TIMEOUT;
      else if (it.kind == KIND_STALL && !halted && n_domains >= stall_ok) r.status = ST_OK;
      else if (halted) r.status = ST_TRIMMED;
      else if (big_list || n_domains >= warn_at) r.status = ST_LARGE;
      else if (n_domains == 0) r.status = ST_EMPTY;
      else r.status = ST_OK;
      r.domain_count = n_domains;
      restart_stream();
    end
    if (produced) expected_results.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // One input transaction, optionally preceded by a random idle burst.
  task automatic send_item(input logic [1:0] k, input logic [7:0] b);
    item_t sent;
    int    gap;
    sent = {k, b};
    gap  = 0;
    if (bursts_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= sent;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (k != KIND_DATA || !halted) items_taken++;
    predict_item(sent);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_DATA, s[i]);
  endtask

  task automatic send_repeat(input logic [7:0] b, input int n);
    repeat (n) send_item(KIND_DATA, b);
  endtask

  // Registers change only once the block has nothing left in flight.
  task automatic set_registers(input logic [15:0] cap, input logic [15:0] warn,
                               input logic [15:0] ok);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_DOMAIN_CAP;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_index <= REG_WARN_COUNT;
    cfg_data  <= warn;
    @(posedge clk);
    cfg_index <= REG_STALL_OK;
    cfg_data  <= ok;
    @(posedge clk);
    cfg_write <= 1'b0;
    dom_cap  = cap;
    warn_at  = warn;
    stall_ok = ok;
  endtask

  // printable token byte, never '#', now and then a high byte
  function automatic logic [7:0] rand_token_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
    c = 8'($urandom_range(33, 126));
    return (c == CH_HASH) ? 8'h2E : c;
  endfunction

  function automatic logic [7:0] rand_blank(input bit with_cr);
    case ($urandom_range(0, with_cr ? 2 : 1))
      0:       return CH_SP;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // A handful of short lines: skipping, comments, held CRs, NUL, top-bit byte.
  task automatic test_smoke();
    send_text(" \0151\th\015x\015\n");  // h, x after one CR, trailing CR dropped
    send_text("#\n");                   // comment line
    send_text("1 #\n");                 // host starts with a comment
    send_text("1 a#\n");                // comment cuts the host
    send_text("1 ");
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, CH_NUL);       // NUL ends the useful part
    send_text("z\n");
    send_item(KIND_END, 8'h00);
  endtask

  // Each end marker kind, empty hosts and an unterminated last line.
  task automatic test_end_status();
    send_item(KIND_END, 8'hFF);
    send_item(KIND_TIMEOUT, 8'h5A);
    send_item(KIND_STALL, 8'hA5);
    send_text("1 \015\015\n1\n\n");     // CR-only host, no host, blank line
    send_text("\t10.0.0.1\t\thost.lan\n");
    send_item(KIND_STALL, 8'h3C);
    send_text("2 ab\n2 cd");            // second line never terminated
    send_item(KIND_TIMEOUT, 8'hC3);
  endtask

  // Line buffer overflow with a host in flight, and a long CR run.
  task automatic test_long_lines();
    send_text("1 ");
    send_repeat("a", LINE_BYTES - 3);
    send_item(KIND_DATA, "b");          // one byte too many: host withdrawn
    send_text("1 c\n");
    send_text("1 ");
    send_repeat(CH_CR, 40);
    send_text("q\n");
    send_item(KIND_END, 8'h81);
  endtask

  // Register extremes: halting at the cap, large list, stall-ok threshold.
  task automatic test_registers();
    set_registers(16'd1, 16'd1, 16'd0);
    send_item(KIND_STALL, 8'h00);       // zero threshold: ok on an empty stream
    send_text("1 a\n");                 // count reaches warn
    send_text("1 b\n");                 // cap hit: abort and halt
    send_text("1 c\n");                 // ignored while halted
    send_item(KIND_END, 8'h11);
    send_text("1 d\n");
    send_item(KIND_TIMEOUT, 8'h22);
    send_item(KIND_END, 8'h33);
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_text("1 e\n2 f\n");
    send_item(KIND_STALL, 8'h44);
    set_registers(16'd3, 16'd2, 16'd2);
    send_text("1 g\n1 h\n1 i\n");
    send_item(KIND_STALL, 8'h55);
    send_text("1 j\n1 k\n");
    send_item(KIND_END, 8'h66);
    set_registers(DOMAIN_CAP_RST, WARN_COUNT_RST, STALL_OK_RST);
  endtask

  // Mostly well-formed lines with random content, some noise and end markers.
  task automatic test_random();
    int target;
    int last_cfg;
    int pick;
    target   = items_taken + RANDOM_ITEMS;
    last_cfg = items_taken;
    while (items_taken < target) begin
      if (target - items_taken < 200) bursts_on = 1'b0;     // quiet tail
      else if ($urandom_range(0, 29) == 0) bursts_on = !bursts_on;
      if (items_taken - last_cfg > 300) begin
        last_cfg = items_taken;
        if ($urandom_range(0, 1) == 0)
          set_registers(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                        16'($urandom_range(0, 6)));
        else
          set_registers(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                        16'($urandom_range(0, 65535)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        // raw noise, sometimes closed by a newline
        repeat ($urandom_range(1, 16)) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) send_item(KIND_DATA, CH_NL);
      end else begin
        repeat ($urandom_range(0, 2)) send_item(KIND_DATA, rand_blank(1'b1));
        repeat ($urandom_range(1, 6)) send_item(KIND_DATA, rand_token_char());
        repeat ($urandom_range(1, 3)) send_item(KIND_DATA, rand_blank(1'b0));
        if ($urandom_range(0, 7) == 0) send_item(KIND_DATA, CH_CR);
        repeat ($urandom_range(1, 10))
          send_item(KIND_DATA, ($urandom_range(0, 7) == 0) ? CH_CR : rand_token_char());
        case ($urandom_range(0, 15))
          0, 1, 2: send_text(" # note");
          3:       send_item(KIND_DATA, CH_HASH);
          4:       send_item(KIND_DATA, CH_NUL);
          default: ;
        endcase
        repeat ($urandom_range(0, 2)) send_item(KIND_DATA, CH_CR);
        if ($urandom_range(0, 29) != 0) send_item(KIND_DATA, CH_NL);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, checking, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      if (bursts_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d", result.result_kind);
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (result.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, result.result_kind);
          fails++;
        end
        if (result.domain_char !== want.domain_char) begin
          $error("domain_char: expected %0d, got %0d", want.domain_char, result.domain_char);
          fails++;
        end
        if (result.cr_before !== want.cr_before) begin
          $error("cr_before: expected %0d, got %0d", want.cr_before, result.cr_before);
          fails++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fails++;
        end
        if (result.domain_count !== want.domain_count) begin
          $error("domain_count: expected %0d, got %0d",
                 want.domain_count, result.domain_count);
          fails++;
        end
      end
    end
  end

  // a hung handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_DOMAIN_CAP;
    cfg_data   = '0;
    dom_cap    = DOMAIN_CAP_RST;
    warn_at    = WARN_COUNT_RST;
    stall_ok   = STALL_OK_RST;
    restart_stream();
    repeat (11) @(posedge clk);
    rst       <= 1'b0;
    bursts_on  = 1'b1;

    test_smoke();
    test_end_status();
    test_long_lines();
    test_registers();
    test_random();

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
